FILE: sv/collision_pair_narrow_phase_core_macros.svh
// assertion macros for the narrow phase core
`ifndef COLLISION_PAIR_NARROW_PHASE_CORE_MACROS_SVH
`define COLLISION_PAIR_NARROW_PHASE_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CPNP_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CPNP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/cpnp_pkg.sv
// ----------------------------------------------------------------------------
// cpnp_pkg
// shared types and constants of the sphere and box narrow phase core
// ----------------------------------------------------------------------------
package cpnp_pkg;

    // fraction bits of positions, extents, depth and points
    localparam int FRAC_BITS = 16;
    localparam int NORM_ONE  = 16384;

    typedef enum logic [1:0] {
        KIND_SPH_SPH = 2'd0,
        KIND_BOX_BOX = 2'd1,
        KIND_BOX_SPH = 2'd2,
        KIND_SPH_BOX = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         pair_kind;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic [30:0]        ext_a_x;
        logic [30:0]        ext_a_y;
        logic [30:0]        ext_a_z;
        logic [30:0]        ext_b_x;
        logic [30:0]        ext_b_y;
        logic [30:0]        ext_b_z;
    } t_pair;

    typedef struct packed {
        logic               hit;
        logic               swapped;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [31:0]        depth;
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_a_z;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic signed [31:0] point_b_z;
    } t_contact;

    // classified work item handed from front to back
    typedef struct packed {
        logic [1:0]         mode;   // t_kind for sphere or box-box, 2 for box-sphere
        logic               swapped;
        logic               early_miss;
        logic signed [34:0] d_x;    // doubled units for box cases
        logic signed [34:0] d_y;
        logic signed [34:0] d_z;
        logic [31:0]        ra;     // first sphere radius or box-sphere radius
        logic [31:0]        r_b;    // second sphere radius
        logic [31:0]        s_x;    // box-box size sums
        logic [31:0]        s_y;
        logic [31:0]        s_z;
    } t_work;

endpackage

FILE: sv/cpnp_stream_if.sv
// ----------------------------------------------------------------------------
// cpnp_stream_if
// valid/ready channel carrying one payload word per transfer
// ----------------------------------------------------------------------------
interface cpnp_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/cpnp_front.sv
// ----------------------------------------------------------------------------
// cpnp_front
// accepts collider pairs, orders roles, clamps box-sphere offsets
// ----------------------------------------------------------------------------
module cpnp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cpnp_pkg::t_pair        i_pair,
    input  logic                   i_valid,
    output logic                   o_ready,
    output cpnp_pkg::t_work        o_work,
    output logic                   o_valid,
    input  logic                   i_ready
);
    logic            r_valid;
    cpnp_pkg::t_work r_work;
    cpnp_pkg::t_work n_work;

    function automatic logic signed [34:0] clamp_rem(input logic signed [34:0] t,
                                                     input logic [30:0] h);
        logic signed [34:0] hs;
        hs = $signed({4'd0, h});
        if (t < -hs) clamp_rem = t + hs;
        else if (t > hs) clamp_rem = t - hs;
        else clamp_rem = '0;
    endfunction

    function automatic logic [33:0] mag35(input logic signed [34:0] v);
        logic [34:0] a;
        a = v[34] ? 35'(-v) : 35'(v);
        mag35 = a[33:0];
    endfunction

    always_comb begin
        logic signed [34:0] tx, ty, tz;
        logic [30:0] bx, by, bz;
        logic [31:0] r;
        logic [32:0] r2;
        logic sw;
        n_work = '0;
        sw = (i_pair.pair_kind == cpnp_pkg::KIND_SPH_BOX);
        tx = 35'(signed'(i_pair.offset_x)) <<< 1;
        ty = 35'(signed'(i_pair.offset_y)) <<< 1;
        tz = 35'(signed'(i_pair.offset_z)) <<< 1;
        if (sw) begin
            tx = -tx;
            ty = -ty;
            tz = -tz;
        end
        bx = sw ? i_pair.ext_b_x : i_pair.ext_a_x;
        by = sw ? i_pair.ext_b_y : i_pair.ext_a_y;
        bz = sw ? i_pair.ext_b_z : i_pair.ext_a_z;
        r  = {1'b0, sw ? i_pair.ext_a_x : i_pair.ext_b_x};
        r2 = {r, 1'b0};
        n_work.mode = i_pair.pair_kind;
        unique case (cpnp_pkg::t_kind'(i_pair.pair_kind))
            cpnp_pkg::KIND_SPH_SPH: begin
                n_work.d_x = 35'(signed'(i_pair.offset_x));
                n_work.d_y = 35'(signed'(i_pair.offset_y));
                n_work.d_z = 35'(signed'(i_pair.offset_z));
                n_work.ra  = {1'b0, i_pair.ext_a_x};
                n_work.r_b = {1'b0, i_pair.ext_b_x};
            end
            cpnp_pkg::KIND_BOX_BOX: begin
                n_work.d_x = tx;
                n_work.d_y = ty;
                n_work.d_z = tz;
                n_work.s_x = 32'(i_pair.ext_a_x) + 32'(i_pair.ext_b_x);
                n_work.s_y = 32'(i_pair.ext_a_y) + 32'(i_pair.ext_b_y);
                n_work.s_z = 32'(i_pair.ext_a_z) + 32'(i_pair.ext_b_z);
                n_work.early_miss = (34'(mag35(tx)) >= 34'(n_work.s_x)) ||
                                    (34'(mag35(ty)) >= 34'(n_work.s_y)) ||
                                    (34'(mag35(tz)) >= 34'(n_work.s_z));
            end
            cpnp_pkg::KIND_BOX_SPH, cpnp_pkg::KIND_SPH_BOX: begin
                n_work.mode    = 2'(cpnp_pkg::KIND_BOX_SPH);
                n_work.swapped = sw;
                n_work.d_x = clamp_rem(tx, bx);
                n_work.d_y = clamp_rem(ty, by);
                n_work.d_z = clamp_rem(tz, bz);
                n_work.ra  = r;
                n_work.early_miss = (mag35(n_work.d_x) >= 34'(r2)) ||
                                    (mag35(n_work.d_y) >= 34'(r2)) ||
                                    (mag35(n_work.d_z) >= 34'(r2));
            end
            default: ;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end
endmodule

FILE: sv/cpnp_fifo.sv
// ----------------------------------------------------------------------------
// cpnp_fifo
// two-entry queue between classification and the arithmetic pipe
// ----------------------------------------------------------------------------
module cpnp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cpnp_pkg::t_work i_work,
    input  logic            i_valid,
    output logic            o_ready,
    output cpnp_pkg::t_work o_work,
    output logic            o_valid,
    input  logic            i_ready
);
    cpnp_pkg::t_work r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_work;
    end

    `include "collision_pair_narrow_phase_core_macros.svh"
    `CPNP_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "fifo count overflow")
    `CPNP_ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, w_push && !w_pop && r_cnt == 2'd0, r_cnt == 2'd1, "fifo count lost a push")
    `CPNP_ASSERT_IMP(a_ptr_sync, i_clk, i_rst_n, r_cnt == 2'd0 || r_cnt == 2'd2, r_wp == r_rp, "fifo pointers out of step")
endmodule

FILE: sv/cpnp_back.sv
// ----------------------------------------------------------------------------
// cpnp_back
// pipelined square root, normalize, divide and point scaling
// ----------------------------------------------------------------------------
module cpnp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpnp_pkg::t_work    i_work,
    input  logic               i_valid,
    output logic               o_ready,
    output cpnp_pkg::t_contact o_res,
    output logic               o_valid,
    input  logic               i_ready
);
    // stage layout: 0 squares, 1 normalized squares, 2..33 both roots two
    // digits per stage, 34 hit decision, 35..50 divide; points scaled at output
    localparam int SQ_ST  = 32;
    localparam int DIV_ST = 16;
    localparam int NST    = 1 + 1 + SQ_ST + 1 + DIV_ST;

    typedef struct packed {
        logic [1:0]   mode;
        logic         swapped;
        logic         miss;
        logic [2:0]   neg;
        logic [31:0]  ra;
        logic [31:0]  rb;
        logic [65:0]  s;      // raw squared length
        logic [65:0]  rem_a;
        logic [32:0]  root_a;
        logic [61:0]  ns;     // normalized sum of squares
        logic [61:0]  rem_b;
        logic [30:0]  root_b;
        logic [29:0]  m_x;
        logic [29:0]  m_y;
        logic [29:0]  m_z;
        logic [15:0]  q_x;
        logic [15:0]  q_y;
        logic [15:0]  q_z;
        logic [44:0]  dr_x;
        logic [44:0]  dr_y;
        logic [44:0]  dr_z;
        logic [2:0]   bb_face;
        logic [31:0]  depth;
        logic         zero;
    } t_pipe;

    t_pipe r_p [NST];
    logic  r_v [NST];
    logic  w_adv;

    assign w_adv   = !r_v[NST-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v[NST-1];

    function automatic logic [33:0] mag(input logic signed [34:0] v);
        logic [34:0] a;
        a = v[34] ? 35'(-v) : 35'(v);
        mag = a[33:0];
    endfunction

    // entry stage: magnitudes, box-box face choice, normalize shift
    function automatic t_pipe enter(input cpnp_pkg::t_work w);
        t_pipe p;
        logic [33:0] mx, my, mz, mm;
        logic [35:0] c [6];
        logic [35:0] best;
        logic [2:0] bi;
        int sh;
        p = '0;
        p.mode = w.mode;
        p.swapped = w.swapped;
        p.miss = w.early_miss;
        p.neg = {w.d_z[34], w.d_y[34], w.d_x[34]};
        p.ra = w.ra;
        p.rb = w.r_b;
        mx = mag(w.d_x);
        my = mag(w.d_y);
        mz = mag(w.d_z);
        p.s = 66'(68'(mx) * 68'(mx) + 68'(my) * 68'(my) + 68'(mz) * 68'(mz));
        mm = mx;
        if (my > mm) mm = my;
        if (mz > mm) mm = mz;
        p.zero = (mm == '0);
        sh = 0;
        for (int k = 0; k < 34; k++) if (mm[k]) sh = k;
        if (sh >= 29) begin
            p.m_x = 30'(mx >> (sh - 29));
            p.m_y = 30'(my >> (sh - 29));
            p.m_z = 30'(mz >> (sh - 29));
        end else begin
            p.m_x = 30'(mx << (29 - sh));
            p.m_y = 30'(my << (29 - sh));
            p.m_z = 30'(mz << (29 - sh));
        end
        c[0] = 36'(signed'({4'd0, w.s_x}) + 36'(w.d_x));
        c[1] = 36'(signed'({4'd0, w.s_x}) - 36'(w.d_x));
        c[2] = 36'(signed'({4'd0, w.s_y}) + 36'(w.d_y));
        c[3] = 36'(signed'({4'd0, w.s_y}) - 36'(w.d_y));
        c[4] = 36'(signed'({4'd0, w.s_z}) + 36'(w.d_z));
        c[5] = 36'(signed'({4'd0, w.s_z}) - 36'(w.d_z));
        best = c[0];
        bi = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (c[k] < best) begin
                best = c[k];
                bi = 3'(k);
            end
        end
        p.bb_face = bi;
        p.depth = 32'(best >> 1);
        return p;
    endfunction

    function automatic t_pipe sq_prep(input t_pipe pi);
        t_pipe p;
        p = pi;
        p.ns = 62'(pi.m_x) * 62'(pi.m_x) + 62'(pi.m_y) * 62'(pi.m_y)
             + 62'(pi.m_z) * 62'(pi.m_z);
        p.rem_a = pi.s;
        p.rem_b = p.ns;
        p.root_a = '0;
        p.root_b = '0;
        return p;
    endfunction

    // two result bits of each root per stage, restoring method
    function automatic t_pipe sq_step(input t_pipe pi, input int st);
        t_pipe p;
        logic [67:0] trial_a;
        logic [63:0] trial_b;
        int bit_a;
        p = pi;
        for (int j = 0; j < 2; j++) begin
            bit_a = 32 - (2 * st + j);
            if (bit_a >= 0) begin
                trial_a = (68'(p.root_a) << (bit_a + 1)) + (68'd1 << (2 * bit_a));
                if (68'(p.rem_a) >= trial_a) begin
                    p.rem_a = 66'(68'(p.rem_a) - trial_a);
                    p.root_a = p.root_a | (33'd1 << bit_a);
                end
            end
            if (bit_a <= 30 && bit_a >= 0) begin
                trial_b = (64'(p.root_b) << (bit_a + 1)) + (64'd1 << (2 * bit_a));
                if (64'(p.rem_b) >= trial_b) begin
                    p.rem_b = 62'(64'(p.rem_b) - trial_b);
                    p.root_b = p.root_b | (31'd1 << bit_a);
                end
            end
        end
        return p;
    endfunction

    function automatic t_pipe div_prep(input t_pipe pi);
        t_pipe p;
        p = pi;
        p.dr_x = 45'({p.m_x, 14'd0}) + 45'(p.root_b >> 1);
        p.dr_y = 45'({p.m_y, 14'd0}) + 45'(p.root_b >> 1);
        p.dr_z = 45'({p.m_z, 14'd0}) + 45'(p.root_b >> 1);
        p.q_x = '0;
        p.q_y = '0;
        p.q_z = '0;
        // hit decision and depth
        unique case (cpnp_pkg::t_kind'(p.mode))
            cpnp_pkg::KIND_SPH_SPH: begin
                p.miss = !(34'(p.ra) + 34'(p.rb) > 34'(p.root_a));
                p.depth = 32'(34'(p.ra) + 34'(p.rb) - 34'(p.root_a));
            end
            cpnp_pkg::KIND_BOX_BOX: ;
            default: begin
                if (!p.miss) p.miss = !(68'(p.s) < 68'(p.ra) * 68'(p.ra) * 68'd4);
                p.depth = 32'((34'({p.ra, 1'b0}) - 34'(p.root_a)) >> 1);
            end
        endcase
        return p;
    endfunction

    // one quotient bit of all three components per step
    function automatic t_pipe div_step(input t_pipe pi, input int st);
        t_pipe p;
        logic [45:0] t;
        int b;
        p = pi;
        b = 15 - st;
        if (p.root_b != '0) begin
            t = 46'(p.root_b) << b;
            if (46'(p.dr_x) >= t) begin p.dr_x = 45'(46'(p.dr_x) - t); p.q_x[b] = 1'b1; end
            if (46'(p.dr_y) >= t) begin p.dr_y = 45'(46'(p.dr_y) - t); p.q_y[b] = 1'b1; end
            if (46'(p.dr_z) >= t) begin p.dr_z = 45'(46'(p.dr_z) - t); p.q_z[b] = 1'b1; end
        end
        return p;
    endfunction

    function automatic logic signed [31:0] scl(input logic [31:0] r, input logic [15:0] q,
                                               input logic neg);
        logic [47:0] m;
        m = (48'(r) * 48'(q) + 48'd8192) >> 14;
        scl = neg ? 32'(-m) : 32'(m);
    endfunction

    function automatic logic signed [15:0] sn(input logic [15:0] q, input logic neg);
        sn = neg ? -q : q;
    endfunction

    cpnp_pkg::t_contact w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_v[k] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) r_v[k] <= r_v[k-1];
        end
        if (w_adv) begin
            r_p[0] <= enter(i_work);
            r_p[1] <= sq_prep(r_p[0]);
            for (int k = 0; k < SQ_ST; k++) r_p[2+k] <= sq_step(r_p[1+k], k);
            r_p[2+SQ_ST] <= div_prep(r_p[1+SQ_ST]);
            for (int k = 0; k < DIV_ST - 1; k++)
                r_p[3+SQ_ST+k] <= div_step(r_p[2+SQ_ST+k], k);
            r_p[NST-1] <= div_step(r_p[NST-2], DIV_ST - 1);
        end
    end

    always_comb begin
        t_pipe p;
        logic [15:0] qx, qy, qz;
        p = r_p[NST-1];
        w_res = '0;
        qx = p.zero ? '0 : p.q_x;
        qy = p.zero ? '0 : p.q_y;
        qz = p.zero ? '0 : p.q_z;
        if (!p.miss) begin
            w_res.hit = 1'b1;
            w_res.swapped = p.swapped;
            w_res.depth = p.depth;
            if (p.mode == 2'(cpnp_pkg::KIND_BOX_BOX)) begin
                unique case (p.bb_face[2:1])
                    2'd0: w_res.normal_x = p.bb_face[0] ? 16'sd16384 : -16'sd16384;
                    2'd1: w_res.normal_y = p.bb_face[0] ? 16'sd16384 : -16'sd16384;
                    default: w_res.normal_z = p.bb_face[0] ? 16'sd16384 : -16'sd16384;
                endcase
            end else begin
                w_res.normal_x = sn(qx, p.neg[0]);
                w_res.normal_y = sn(qy, p.neg[1]);
                w_res.normal_z = sn(qz, p.neg[2]);
                w_res.point_b_x = -scl(p.ra, qx, p.neg[0]);
                w_res.point_b_y = -scl(p.ra, qy, p.neg[1]);
                w_res.point_b_z = -scl(p.ra, qz, p.neg[2]);
                if (p.mode == 2'(cpnp_pkg::KIND_SPH_SPH)) begin
                    w_res.point_a_x = scl(p.ra, qx, p.neg[0]);
                    w_res.point_a_y = scl(p.ra, qy, p.neg[1]);
                    w_res.point_a_z = scl(p.ra, qz, p.neg[2]);
                    w_res.point_b_x = -scl(p.rb, qx, p.neg[0]);
                    w_res.point_b_y = -scl(p.rb, qy, p.neg[1]);
                    w_res.point_b_z = -scl(p.rb, qz, p.neg[2]);
                end
            end
        end
    end

    assign o_res = w_res;

    `include "collision_pair_narrow_phase_core_macros.svh"
    `CPNP_ASSERT_IMP(a_miss_quiet, i_clk, i_rst_n, o_valid && !o_res.hit, o_res.depth == '0 && !o_res.swapped, "miss carries payload")
    `CPNP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped under stall")
    `CPNP_ASSERT_IMP(a_swap_hit, i_clk, i_rst_n, o_valid && o_res.swapped, o_res.hit, "swap flag without hit")
endmodule

FILE: sv/collision_pair_narrow_phase_core.sv
// ----------------------------------------------------------------------------
// collision_pair_narrow_phase_core
// sphere and box narrow phase contact test
// ----------------------------------------------------------------------------
// one collider pair enters on i_pair per transfer, one contact record
// leaves on o_contact per transfer, in order
// the front stage classifies the pair, orders box before sphere and
// clamps the offset; a two-entry queue decouples it from the back pipe
// the back pipe computes two square roots two bits a stage and a
// sixteen-step divide for the normal, then scales the contact points
// throughput is one pair per cycle while the receiver is ready, set by
// the fully pipelined root and divide stages
// reset is synchronous and empties the front register, queue and pipe
// a stalled receiver freezes the back pipe; the queue absorbs the items
// in flight and then the front deasserts ready
// ----------------------------------------------------------------------------
module collision_pair_narrow_phase_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpnp_stream_if.sink   i_pair,
    cpnp_stream_if.source o_contact
);
    cpnp_pkg::t_work w_fw;
    logic            w_fv;
    logic            w_fr;
    cpnp_pkg::t_work w_qw;
    logic            w_qv;
    logic            w_qr;
    cpnp_pkg::t_contact w_res;

    cpnp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (cpnp_pkg::t_pair'(i_pair.data)),
        .i_valid (i_pair.valid),
        .o_ready (i_pair.ready),
        .o_work  (w_fw),
        .o_valid (w_fv),
        .i_ready (w_fr)
    );

    cpnp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (w_fw),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .o_work  (w_qw),
        .o_valid (w_qv),
        .i_ready (w_qr)
    );

    cpnp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (w_qw),
        .i_valid (w_qv),
        .o_ready (w_qr),
        .o_res   (w_res),
        .o_valid (o_contact.valid),
        .i_ready (o_contact.ready)
    );

    assign o_contact.data = w_res;
endmodule

FILE: dv/cpnp_contact_checker.sv
// ----------------------------------------------------------------------------
// cpnp_contact_checker
// watches the pair and contact channels, computes the expected contact
// record of every accepted pair and compares each result field by field
// ----------------------------------------------------------------------------
module cpnp_contact_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pair_valid,
    input  logic               i_pair_ready,
    input  cpnp_pkg::t_pair    i_pair_data,
    input  logic               i_contact_valid,
    input  logic               i_contact_ready,
    input  cpnp_pkg::t_contact i_contact_data,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    cpnp_pkg::t_contact expected_contacts[$];

    assign o_pending = expected_contacts.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void unit_normal(input logic signed [63:0] d[3],
                                        output logic signed [15:0] n[3]);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] q;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(d[i]);
            if (m[i] > mx) mx = m[i];
        end
        for (int i = 0; i < 3; i++) n[i] = 0;
        if (mx == 0) return;
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 14) + (len >> 1)) / len;
            n[i] = d[i] < 0 ? -q[15:0] : q[15:0];
        end
    endfunction

    function automatic logic [31:0] radius_point(input logic [63:0] r,
                                                 input logic signed [15:0] n);
        logic [63:0] nm;
        logic [63:0] mg;
        nm = n < 0 ? -64'(n) : 64'(n);
        mg = (r * nm + 64'd8192) >> 14;
        return n < 0 ? -mg[31:0] : mg[31:0];
    endfunction

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic cpnp_pkg::t_contact pair_contact(input cpnp_pkg::t_pair p);
        cpnp_pkg::t_contact c;
        logic signed [63:0] off[3];
        logic signed [63:0] d[3];
        logic [63:0] ea[3];
        logic [63:0] eb[3];
        logic [63:0] box[3];
        logic signed [15:0] n[3];
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] sq;
        logic signed [63:0] t;
        logic signed [63:0] h;
        logic signed [63:0] cl;
        logic signed [63:0] best;
        logic signed [63:0] cand;
        int bi;
        logic ok;
        c = '0;
        off[0] = 64'(p.offset_x);
        off[1] = 64'(p.offset_y);
        off[2] = 64'(p.offset_z);
        ea[0] = p.ext_a_x; ea[1] = p.ext_a_y; ea[2] = p.ext_a_z;
        eb[0] = p.ext_b_x; eb[1] = p.ext_b_y; eb[2] = p.ext_b_z;
        case (cpnp_pkg::t_kind'(p.pair_kind))
            cpnp_pkg::KIND_SPH_SPH: begin
                s = 0;
                for (int i = 0; i < 3; i++) s = s + mag64(off[i]) * mag64(off[i]);
                sq = int_sqrt(s);
                if (ea[0] + eb[0] > sq) begin
                    c.hit = 1'b1;
                    c.depth = clip32(ea[0] + eb[0] - sq);
                    unit_normal(off, n);
                    c.normal_x = n[0]; c.normal_y = n[1]; c.normal_z = n[2];
                    c.point_a_x = radius_point(ea[0], n[0]);
                    c.point_a_y = radius_point(ea[0], n[1]);
                    c.point_a_z = radius_point(ea[0], n[2]);
                    c.point_b_x = -radius_point(eb[0], n[0]);
                    c.point_b_y = -radius_point(eb[0], n[1]);
                    c.point_b_z = -radius_point(eb[0], n[2]);
                end
            end
            cpnp_pkg::KIND_BOX_BOX: begin
                ok = 1'b1;
                for (int i = 0; i < 3; i++)
                    if (2 * mag64(off[i]) >= ea[i] + eb[i]) ok = 1'b0;
                if (ok) begin
                    bi = -1;
                    best = 0;
                    for (int i = 0; i < 6; i++) begin
                        cand = (i & 1) ? $signed(ea[i>>1] + eb[i>>1]) - 2 * off[i>>1]
                                       : $signed(ea[i>>1] + eb[i>>1]) + 2 * off[i>>1];
                        if (bi < 0 || cand < best) begin
                            best = cand;
                            bi = i;
                        end
                    end
                    for (int i = 0; i < 3; i++) n[i] = 0;
                    n[bi>>1] = (bi & 1) ? 16'(cpnp_pkg::NORM_ONE) : -16'(cpnp_pkg::NORM_ONE);
                    c.hit = 1'b1;
                    c.depth = clip32(best >> 1);
                    c.normal_x = n[0]; c.normal_y = n[1]; c.normal_z = n[2];
                end
            end
            default: begin
                for (int i = 0; i < 3; i++)
                    box[i] = (p.pair_kind == cpnp_pkg::KIND_BOX_SPH) ? ea[i] : eb[i];
                r = (p.pair_kind == cpnp_pkg::KIND_BOX_SPH) ? eb[0] : ea[0];
                ok = 1'b1;
                s = 0;
                for (int i = 0; i < 3; i++) begin
                    t = 2 * ((p.pair_kind == cpnp_pkg::KIND_BOX_SPH) ? off[i] : -off[i]);
                    h = box[i];
                    cl = t < -h ? -h : (t > h ? h : t);
                    d[i] = t - cl;
                    if (mag64(d[i]) >= 2 * r) ok = 1'b0;
                end
                if (ok) begin
                    for (int i = 0; i < 3; i++) begin
                        sq = mag64(d[i]) * mag64(d[i]);
                        if (s + sq < s) ok = 1'b0;
                        s = s + sq;
                    end
                end
                if (ok && s < 4 * r * r) begin
                    c.hit = 1'b1;
                    c.swapped = (p.pair_kind == cpnp_pkg::KIND_SPH_BOX);
                    c.depth = clip32((2 * r - int_sqrt(s)) >> 1);
                    unit_normal(d, n);
                    c.normal_x = n[0]; c.normal_y = n[1]; c.normal_z = n[2];
                    c.point_b_x = -radius_point(r, n[0]);
                    c.point_b_y = -radius_point(r, n[1]);
                    c.point_b_z = -radius_point(r, n[2]);
                end
            end
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        cpnp_pkg::t_contact w;
        if (i_rst_n && i_pair_valid && i_pair_ready)
            expected_contacts.insert(expected_contacts.size(), pair_contact(i_pair_data));
        if (i_rst_n && i_contact_valid && i_contact_ready) begin
            if (expected_contacts.size() == 0) begin
                report_mismatch("unexpected contact", i_contact_data.depth, 0);
            end else begin
                w = expected_contacts.pop_front();
                if (i_contact_data.hit !== w.hit)
                    report_mismatch("hit", i_contact_data.hit, w.hit);
                if (i_contact_data.swapped !== w.swapped)
                    report_mismatch("swapped", i_contact_data.swapped, w.swapped);
                if (i_contact_data.normal_x !== w.normal_x)
                    report_mismatch("normal_x", i_contact_data.normal_x, w.normal_x);
                if (i_contact_data.normal_y !== w.normal_y)
                    report_mismatch("normal_y", i_contact_data.normal_y, w.normal_y);
                if (i_contact_data.normal_z !== w.normal_z)
                    report_mismatch("normal_z", i_contact_data.normal_z, w.normal_z);
                if (i_contact_data.depth !== w.depth)
                    report_mismatch("depth", i_contact_data.depth, w.depth);
                if (i_contact_data.point_a_x !== w.point_a_x)
                    report_mismatch("point_a_x", i_contact_data.point_a_x, w.point_a_x);
                if (i_contact_data.point_a_y !== w.point_a_y)
                    report_mismatch("point_a_y", i_contact_data.point_a_y, w.point_a_y);
                if (i_contact_data.point_a_z !== w.point_a_z)
                    report_mismatch("point_a_z", i_contact_data.point_a_z, w.point_a_z);
                if (i_contact_data.point_b_x !== w.point_b_x)
                    report_mismatch("point_b_x", i_contact_data.point_b_x, w.point_b_x);
                if (i_contact_data.point_b_y !== w.point_b_y)
                    report_mismatch("point_b_y", i_contact_data.point_b_y, w.point_b_y);
                if (i_contact_data.point_b_z !== w.point_b_z)
                    report_mismatch("point_b_z", i_contact_data.point_b_z, w.point_b_z);
            end
        end
    end
endmodule

FILE: dv/tb_collision_pair_narrow_phase_core.sv
// ----------------------------------------------------------------------------
// tb_collision_pair_narrow_phase_core
// drives directed and random collider pairs of every kind with random
// gaps on both channels; a checker module predicts and compares contacts
// ----------------------------------------------------------------------------
module tb_collision_pair_narrow_phase_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    logic calm;

    cpnp_pkg::t_pair directed[$];

    cpnp_stream_if #(.W($bits(cpnp_pkg::t_pair)))    pair_ch ();
    cpnp_stream_if #(.W($bits(cpnp_pkg::t_contact))) contact_ch ();

    collision_pair_narrow_phase_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pair    (pair_ch.sink),
        .o_contact (contact_ch.source)
    );

    cpnp_contact_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pair_valid    (pair_ch.valid),
        .i_pair_ready    (pair_ch.ready),
        .i_pair_data     (cpnp_pkg::t_pair'(pair_ch.data)),
        .i_contact_valid (contact_ch.valid),
        .i_contact_ready (contact_ch.ready),
        .i_contact_data  (cpnp_pkg::t_contact'(contact_ch.data)),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // receiver stalls in bursts
    initial begin
        int n;
        contact_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 15);
                contact_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            contact_ch.ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    function automatic logic [30:0] rnd_ext(input int sz);
        case (sz)
            0: return 31'($urandom_range(0, 32'h0004_0000));
            1: return 31'($urandom_range(0, 32'h0100_0000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_off(input logic [30:0] reach);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom;
        if (sel == 1) return 0;
        return $signed(32'($urandom_range(0, 32'(reach)))) *
               ($urandom_range(0, 1) ? 1 : -1);
    endfunction

    function automatic cpnp_pkg::t_pair random_pair();
        cpnp_pkg::t_pair p;
        int sz;
        logic [30:0] reach;
        sz = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        p.pair_kind = 2'($urandom_range(0, 3));
        p.ext_a_x = rnd_ext(sz); p.ext_a_y = rnd_ext(sz); p.ext_a_z = rnd_ext(sz);
        p.ext_b_x = rnd_ext(sz); p.ext_b_y = rnd_ext(sz); p.ext_b_z = rnd_ext(sz);
        reach = (p.ext_a_x >> 1) + (p.ext_b_x >> 1);
        p.offset_x = rnd_off(reach);
        reach = (p.ext_a_y >> 1) + (p.ext_b_y >> 1);
        p.offset_y = rnd_off(reach);
        reach = (p.ext_a_z >> 1) + (p.ext_b_z >> 1);
        p.offset_z = rnd_off(reach);
        return p;
    endfunction

    task automatic send_pair(input cpnp_pkg::t_pair p);
        if (!calm && $urandom_range(0, 3) == 0) begin
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.data  <= p;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic cpnp_pkg::t_pair make_pair(input cpnp_pkg::t_kind k,
                                                  input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] z,
                                                  input logic [30:0] a,
                                                  input logic [30:0] b);
        cpnp_pkg::t_pair p;
        p.pair_kind = k;
        p.offset_x = x; p.offset_y = y; p.offset_z = z;
        p.ext_a_x = a; p.ext_a_y = a; p.ext_a_z = a;
        p.ext_b_x = b; p.ext_b_y = b; p.ext_b_z = b;
        return p;
    endfunction

    function automatic void add_directed(input cpnp_pkg::t_kind k,
                                         input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input logic signed [31:0] z,
                                         input logic [30:0] a,
                                         input logic [30:0] b);
        directed.insert(directed.size(), make_pair(k, x, y, z, a, b));
    endfunction

    initial begin
        calm = 1'b0;
        i_rst_n = 1'b0;
        pair_ch.valid = 1'b0;
        pair_ch.data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        // coincident centers, misses, saturation, extremes, swaps
        add_directed(cpnp_pkg::KIND_SPH_SPH, 0, 0, 0, 31'h10000, 31'h10000);
        add_directed(cpnp_pkg::KIND_SPH_SPH, 32'h30000, 0, 0, 31'h10000, 31'h10000);
        add_directed(cpnp_pkg::KIND_SPH_SPH, 32'h20000, 0, 0, 31'h10000, 31'h10000);
        add_directed(cpnp_pkg::KIND_SPH_SPH, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     31'h7FFFFFFF, 31'h7FFFFFFF);
        add_directed(cpnp_pkg::KIND_SPH_SPH, -32'sh8000, 32'h4000, -32'sh1, 0, 0);
        add_directed(cpnp_pkg::KIND_BOX_BOX, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF);
        add_directed(cpnp_pkg::KIND_BOX_BOX, 0, 0, 0, 0, 0);
        add_directed(cpnp_pkg::KIND_BOX_BOX, 32'h10000, 0, 0, 31'h20000, 31'h20000);
        add_directed(cpnp_pkg::KIND_BOX_BOX, -32'sh8000, 32'h100, 0, 31'h20000, 31'h20000);
        add_directed(cpnp_pkg::KIND_BOX_BOX, 32'h80000000, 32'h80000000, 32'h80000000,
                     31'h7FFFFFFF, 31'h7FFFFFFF);
        add_directed(cpnp_pkg::KIND_BOX_SPH, 0, 0, 0, 31'h20000, 31'h10000);
        add_directed(cpnp_pkg::KIND_BOX_SPH, 32'h18000, 0, 0, 31'h20000, 31'h10000);
        add_directed(cpnp_pkg::KIND_BOX_SPH, 32'h18000, 32'h18000, 32'h18000,
                     31'h20000, 31'h10000);
        add_directed(cpnp_pkg::KIND_BOX_SPH, 32'h20000, 0, 0, 31'h20000, 31'h10000);
        add_directed(cpnp_pkg::KIND_BOX_SPH, 32'h7FFFFFFF, 32'h80000000, 0,
                     0, 31'h7FFFFFFF);
        add_directed(cpnp_pkg::KIND_SPH_BOX, 32'h18000, 0, 0, 31'h10000, 31'h20000);
        add_directed(cpnp_pkg::KIND_SPH_BOX, -32'sh18000, 32'h100, 0,
                     31'h10000, 31'h20000);
        add_directed(cpnp_pkg::KIND_SPH_BOX, 0, 0, 0, 31'h10000, 31'h20000);
        add_directed(cpnp_pkg::KIND_SPH_BOX, 32'h80000000, 32'h80000000, 32'h80000000,
                     31'h7FFFFFFF, 31'h7FFFFFFF);
        foreach (directed[i]) send_pair(directed[i]);
        for (int i = 0; i < 450; i++) begin
            if (i == 380) calm = 1'b1;
            send_pair(random_pair());
        end
        pair_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/cpnp_pkg.sv
sv/cpnp_stream_if.sv
sv/cpnp_front.sv
sv/cpnp_fifo.sv
sv/cpnp_back.sv
sv/collision_pair_narrow_phase_core.sv
dv/cpnp_contact_checker.sv
dv/tb_collision_pair_narrow_phase_core.sv
